// ===== rtl/core/i64dg_pkg.sv =====
// Package for the signed 64-bit divide / GCD math unit.
// Holds data widths, mode codes, controller states and the control structs.
// No dependencies; every other file of the unit imports it.
package i64dg_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned SHIFT_W = 6;   // bit index into a data word

  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_ABS    = 3'd0,
    MODE_MIN    = 3'd1,
    MODE_MAX    = 3'd2,
    MODE_CLAMP  = 3'd3,
    MODE_SIGN   = 3'd4,
    MODE_DIVMOD = 3'd5,
    MODE_GCD    = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_GCD,
    ST_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch a new request
    logic div_step;  // one restoring divide step
    logic gcd_step;  // one binary GCD step
    logic res_load;  // write the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_div;  // incoming request is a divide by a nonzero divisor
    logic start_gcd;  // incoming request is a GCD
    logic gcd_done;   // one GCD operand reached zero
  } status_t;

endpackage

// ===== rtl/core/i64dg_req_if.sv =====
// Request channel of the math unit: valid/ready plus mode and three operands.
// Depends on i64dg_pkg.
interface i64dg_req_if import i64dg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] operand_a;
  logic signed [DATA_W-1:0] operand_b;
  logic signed [DATA_W-1:0] operand_c;

  modport source (output valid, mode, operand_a, operand_b, operand_c, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, operand_c, output ready);
endinterface

// ===== rtl/core/i64dg_rsp_if.sv =====
// Response channel of the math unit: valid/ready plus value, remainder, none flag.
// Depends on i64dg_pkg.
interface i64dg_rsp_if import i64dg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] remainder;
  logic                     is_none;

  modport source (output valid, value, remainder, is_none, input ready);
  modport sink   (input valid, value, remainder, is_none, output ready);
endinterface

// ===== rtl/core/int64_divmod_gcd_unit.sv =====
// Top level of the signed 64-bit divide / GCD math unit.
// Instantiates i64dg_ctrl and i64dg_dp; uses i64dg_pkg, i64dg_req_if, i64dg_rsp_if.
//
// Usage:
//   req: valid/ready channel carrying mode and operands a, b, c. A request is
//        taken on a clock edge with valid and ready high. Ready is high
//        whenever no request is in work, also while a result still waits.
//   rsp: valid/ready channel carrying value, remainder and is_none. The
//        result sits in an output register until the receiver takes it.
// Work per request:
//   abs, min, max, clamp, sign, divide by zero: result written with no steps.
//   divmod: 64 restoring radix-2 steps on one 65-bit subtractor.
//   gcd: binary GCD steps on the u and v registers shared with the divider,
//        until one operand reaches zero.
// One request is in work at a time; the next can be taken in the cycle after the
// result is loaded into the output register.
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops
// any pending result. When the receiver stalls, the result holds in the
// output register; one further request may be accepted and worked on, and
// its result waits until the register frees.
module int64_divmod_gcd_unit import i64dg_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  i64dg_req_if.sink   req,
  i64dg_rsp_if.source rsp
);

  cmd_t    cmd;
  status_t status;

  // sequencing: idle / divide / gcd / write result
  i64dg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // operand registers, shift/subtract unit, result register
  i64dg_dp u_dp (
    .clk_i       (clk_i),
    .mode_i      (req.mode),
    .operand_a_i (req.operand_a),
    .operand_b_i (req.operand_b),
    .operand_c_i (req.operand_c),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_o     (rsp.value),
    .remainder_o (rsp.remainder),
    .is_none_o   (rsp.is_none)
  );

endmodule

// ===== rtl/core/i64dg_dp.sv =====
// Datapath of the math unit: operand registers, u/v registers shared by the
// restoring divider and the binary GCD, result selection and output register.
// Depends on i64dg_pkg.
module i64dg_dp import i64dg_pkg::*; (
  input  logic                     clk_i,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic signed [DATA_W-1:0] operand_a_i,
  input  logic signed [DATA_W-1:0] operand_b_i,
  input  logic signed [DATA_W-1:0] operand_c_i,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  output logic signed [DATA_W-1:0] value_o,
  output logic signed [DATA_W-1:0] remainder_o,
  output logic                     is_none_o
);

  logic [MODE_W-1:0]        mode_q;
  logic signed [DATA_W-1:0] a_q, b_q, c_q;
  logic [DATA_W-1:0]        u_q, u_d;   // |a|; quotient shift register while dividing
  logic [DATA_W-1:0]        v_q, v_d;   // |b|; divisor while dividing
  logic [DATA_W-1:0]        r_q, r_d;   // partial remainder
  logic [SHIFT_W-1:0]       k_q, k_d;   // common power of two in GCD
  logic signed [DATA_W-1:0] val_q, val_d, rem_q, rem_d;
  logic                     none_q, none_d;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_diff;
  logic              trial_ge;
  logic              u_ge_v;
  logic [DATA_W-1:0] mag_a_in, mag_b_in;
  logic [DATA_W-1:0] gcd_base;
  logic signed [DATA_W-1:0] lo_min;

  assign mag_a_in = operand_a_i[DATA_W-1] ? (DATA_W'(0) - operand_a_i) : operand_a_i;
  assign mag_b_in = operand_b_i[DATA_W-1] ? (DATA_W'(0) - operand_b_i) : operand_b_i;

  assign status_o.start_div = (mode_i == MODE_DIVMOD) && (operand_b_i != '0);
  assign status_o.start_gcd = (mode_i == MODE_GCD);
  assign status_o.gcd_done  = (u_q == '0) || (v_q == '0);

  // restoring divide step
  assign trial      = {r_q, u_q[DATA_W-1]};
  assign trial_diff = trial - {1'b0, v_q};
  assign trial_ge   = ~trial_diff[DATA_W];
  assign u_ge_v     = (u_q >= v_q);

  always_comb begin
    u_d = u_q;
    v_d = v_q;
    r_d = r_q;
    k_d = k_q;
    if (cmd_i.load) begin
      u_d = mag_a_in;
      v_d = mag_b_in;
      r_d = '0;
      k_d = '0;
    end else if (cmd_i.div_step) begin
      r_d = trial_ge ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
      u_d = {u_q[DATA_W-2:0], trial_ge};
    end else if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_d = u_q >> 1;
        v_d = v_q >> 1;
        k_d = k_q + SHIFT_W'(1);
      end else if (!u_q[0]) begin
        u_d = u_q >> 1;
      end else if (!v_q[0]) begin
        v_d = v_q >> 1;
      end else if (u_ge_v) begin
        u_d = u_q - v_q;
      end else begin
        v_d = v_q - u_q;
      end
    end
  end

  assign gcd_base = (u_q == '0) ? v_q : u_q;
  assign lo_min   = (a_q < c_q) ? a_q : c_q;

  always_comb begin
    val_d  = '0;
    rem_d  = '0;
    none_d = 1'b0;
    case (mode_q)
      MODE_ABS:    val_d = a_q[DATA_W-1] ? (DATA_W'(0) - a_q) : a_q;
      MODE_MIN:    val_d = (b_q < a_q) ? b_q : a_q;
      MODE_MAX:    val_d = (a_q < b_q) ? b_q : a_q;
      MODE_CLAMP:  val_d = (b_q < lo_min) ? lo_min : b_q;
      MODE_SIGN:   val_d = a_q[DATA_W-1] ? '1 : ((a_q != '0) ? DATA_W'(1) : '0);
      MODE_DIVMOD: begin
        if (b_q == '0) begin
          none_d = 1'b1;
        end else begin
          val_d = (a_q[DATA_W-1] ^ b_q[DATA_W-1]) ? (DATA_W'(0) - u_q) : u_q;
          rem_d = a_q[DATA_W-1] ? (DATA_W'(0) - r_q) : r_q;
        end
      end
      MODE_GCD:    val_d = gcd_base << k_q;
      default:     val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      c_q    <= operand_c_i;
    end
    u_q <= u_d;
    v_q <= v_d;
    r_q <= r_d;
    k_q <= k_d;
    if (cmd_i.res_load) begin
      val_q  <= val_d;
      rem_q  <= rem_d;
      none_q <= none_d;
    end
  end

  assign value_o     = val_q;
  assign remainder_o = rem_q;
  assign is_none_o   = none_q;

endmodule

// ===== rtl/core/i64dg_ctrl.sv =====
// Controller of the math unit: state machine, divide step counter and
// output valid flag. Drives the datapath through cmd_t, reads status_t.
// Depends on i64dg_pkg.
module i64dg_ctrl import i64dg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e             state_q, state_d;
  logic [SHIFT_W-1:0] cnt_q, cnt_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic               div_last;

  assign div_last = (cnt_q == '1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (status_i.start_div)      state_d = ST_DIV;
          else if (status_i.start_gcd) state_d = ST_GCD;
          else                         state_d = ST_FINISH;
        end
      end
      ST_DIV:    if (div_last) state_d = ST_FINISH;
      ST_GCD:    if (status_i.gcd_done) state_d = ST_FINISH;
      ST_FINISH: if (!rsp_valid_q || rsp_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_GCD:    cmd_o.gcd_step = !status_i.gcd_done;
      ST_FINISH: cmd_o.res_load = !rsp_valid_q || rsp_ready_i;
      default:   cmd_o = '0;
    endcase
  end

  assign cnt_d       = cmd_o.load ? '0 : (cmd_o.div_step ? cnt_q + SHIFT_W'(1) : cnt_q);
  assign rsp_valid_d = cmd_o.res_load | (rsp_valid_q & ~rsp_ready_i);
  assign rsp_valid_o = rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  a_load_clears_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (cnt_q == '0))
    else $error("divide counter not cleared on request");

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!rsp_valid_q || rsp_ready_i))
    else $error("output register overwritten while full");

  a_res_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> rsp_valid_q)
    else $error("result loaded but not presented");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_last) |=> (state_q == ST_FINISH))
    else $error("divide did not end after last step");

  a_steps_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.div_step, cmd_o.gcd_step, cmd_o.res_load}))
    else $error("conflicting datapath commands");

endmodule

// ===== sim/int64_divmod_gcd_unit_tb.sv =====
// Self-checking testbench for int64_divmod_gcd_unit: directed and random requests,
// checked against an in-bench predictor of all seven math modes.
// Depends on i64dg_pkg, i64dg_req_if, i64dg_rsp_if and the unit's RTL.
`timescale 1ns / 1ps

module int64_divmod_gcd_unit_tb;
  import i64dg_pkg::*;

  // Mode code seven is not in mode_e; the unit must return an all-zero result.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  localparam logic signed [DATA_W-1:0] S64_MIN = MOST_NEG;
  localparam logic signed [DATA_W-1:0] S64_MAX = ~MOST_NEG;

  localparam int unsigned RANDOM_REQS = 1400;
  localparam int unsigned DRAIN_CYCLES = 250;  // longer than the slowest GCD

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [DATA_W-1:0] op_c;
  } math_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] remainder;
    logic                     is_none;
  } math_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  i64dg_req_if req_if ();
  i64dg_rsp_if rsp_if ();

  int64_divmod_gcd_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if.sink),
    .rsp    (rsp_if.source)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  math_req_t pending_reqs[$];     // requests not yet taken by the unit
  math_rsp_t expected_results[$]; // predicted results, oldest first
  bit        any_mismatch = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor: bit-exact behavior of every mode at 64 bits two's complement.
  // ---------------------------------------------------------------------------
  function automatic math_rsp_t compute_math_result(math_req_t r);
    math_rsp_t                res;
    logic signed [DATA_W-1:0] low_cap;
    logic [DATA_W-1:0]        mag_a;
    logic [DATA_W-1:0]        mag_b;
    logic [DATA_W-1:0]        quot;
    logic [DATA_W-1:0]        rmd;
    logic [DATA_W-1:0]        tmp;
    res.value     = '0;
    res.remainder = '0;
    res.is_none   = 1'b0;
    // magnitudes wrap, so the most negative value keeps its own bit pattern
    mag_a = r.op_a[DATA_W-1] ? (DATA_W'(0) - r.op_a) : r.op_a;
    mag_b = r.op_b[DATA_W-1] ? (DATA_W'(0) - r.op_b) : r.op_b;
    case (r.mode)
      MODE_ABS:   res.value = mag_a;
      MODE_MIN:   res.value = (r.op_b < r.op_a) ? r.op_b : r.op_a;
      MODE_MAX:   res.value = (r.op_a < r.op_b) ? r.op_b : r.op_a;
      MODE_CLAMP: begin
        // max(lo, min(x, hi)): crossed bounds give lo
        low_cap   = (r.op_c < r.op_a) ? r.op_c : r.op_a;
        res.value = (r.op_b < low_cap) ? low_cap : r.op_b;
      end
      MODE_SIGN: begin
        if (r.op_a < 0) res.value = -1;
        else if (r.op_a != 0) res.value = 1;
        else res.value = 0;
      end
      MODE_DIVMOD: begin
        if (r.op_b == 0) begin
          res.is_none = 1'b1;
        end else begin
          quot = mag_a / mag_b;
          rmd  = mag_a % mag_b;
          // most negative / -1 wraps back to the most negative value here
          res.value     = (r.op_a[DATA_W-1] != r.op_b[DATA_W-1]) ? (DATA_W'(0) - quot) : quot;
          res.remainder = r.op_a[DATA_W-1] ? (DATA_W'(0) - rmd) : rmd;
        end
      end
      MODE_GCD: begin
        // Euclid on unsigned magnitudes; a result of 2^63 shows as the most
        // negative value
        while (mag_b != 0) begin
          tmp   = mag_a % mag_b;
          mag_a = mag_b;
          mag_b = tmp;
        end
        res.value = mag_a;
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_edge_value();
    case ($urandom_range(0, 5))
      0:       return S64_MIN;
      1:       return S64_MAX;
      2:       return 0;
      3:       return 1;
      4:       return -1;
      default: return S64_MIN + 1;
    endcase
  endfunction

  // Mix full-width, small, edge and shortened values so that compares and
  // divides see both tiny and huge magnitudes.
  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2: return rand_word();
      3, 4:    return $signed(DATA_W'($urandom_range(0, 40))) - 20;
      5:       return pick_edge_value();
      default: return rand_word() >>> $urandom_range(1, 62);
    endcase
  endfunction

  task automatic push_req(input logic [MODE_W-1:0] mode,
                          input logic signed [DATA_W-1:0] op_a,
                          input logic signed [DATA_W-1:0] op_b,
                          input logic signed [DATA_W-1:0] op_c);
    math_req_t r;
    r.mode = mode;
    r.op_a = op_a;
    r.op_b = op_b;
    r.op_c = op_c;
    pending_reqs.push_back(r);
  endtask

  task automatic push_random_req();
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [DATA_W-1:0] op_c;
    logic signed [DATA_W-1:0] factor;
    mode = MODE_W'($urandom_range(0, 6));
    op_a = pick_operand();
    op_b = pick_operand();
    op_c = pick_operand();
    case (mode)
      MODE_CLAMP: begin
        // mostly ordered bounds so the subject lands on every side
        if ($urandom_range(0, 3) != 0 && op_c < op_b) begin
          factor = op_b;
          op_b   = op_c;
          op_c   = factor;
        end
      end
      MODE_DIVMOD: begin
        case ($urandom_range(0, 9))
          0:       op_b = 0;
          1:       op_b = -1;
          2:       op_b = $signed(DATA_W'($urandom_range(1, 16))) * ($urandom_range(0, 1) ? 1 : -1);
          default: ;
        endcase
      end
      MODE_GCD: begin
        // share a common factor so the answer is not almost always one
        if ($urandom_range(0, 2) != 0) begin
          factor = DATA_W'($urandom_range(1, 1 << $urandom_range(1, 24)));
          op_a   = factor * $signed(DATA_W'($urandom) >> $urandom_range(0, 31));
          op_b   = factor * $signed(DATA_W'($urandom) >> $urandom_range(0, 31));
          if ($urandom_range(0, 1)) op_a = -op_a;
          if ($urandom_range(0, 1)) op_b = -op_b;
        end
      end
      default: ;
    endcase
    push_req(mode, op_a, op_b, op_c);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps in between.
  // A request once offered holds until the unit takes it.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  initial begin
    req_if.valid     = 1'b0;
    req_if.mode      = '0;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    req_if.operand_c = '0;
    rsp_if.ready     = 1'b0;
  end

  always @(posedge clk_i) begin
    bit offer;
    bit holding;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      holding = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        // request taken at this edge: predict its result and drop it
        expected_results.push_back(compute_math_result(pending_reqs[0]));
        void'(pending_reqs.pop_front());
        holding = 1'b0;
      end
      if (holding) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        offer = 1'b0;
      end else if (pending_reqs.size() > 0) begin
        offer = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 8);
            8:          gap_left = $urandom_range(9, 60);
            default:    gap_left = $urandom_range(61, 200);
          endcase
        end
      end else begin
        offer = 1'b0;
      end
      req_if.valid <= offer;
      if (offer && !holding) begin
        req_if.mode      <= pending_reqs[0].mode;
        req_if.operand_a <= pending_reqs[0].op_a;
        req_if.operand_b <= pending_reqs[0].op_b;
        req_if.operand_c <= pending_reqs[0].op_c;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver: check each taken result against the oldest
  // prediction, and stall on alternating runs of ready and not ready.
  // ---------------------------------------------------------------------------
  int unsigned ready_run = 0;
  int unsigned stall_run = 0;

  always @(posedge clk_i) begin
    math_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: value %0d", rsp_if.value);
          any_mismatch = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, rsp_if.value);
            any_mismatch = 1'b1;
          end
          if (rsp_if.remainder !== want.remainder) begin
            $error("remainder: expected %0d, got %0d", want.remainder, rsp_if.remainder);
            any_mismatch = 1'b1;
          end
          if (rsp_if.is_none !== want.is_none) begin
            $error("is_none: expected %0b, got %0b", want.is_none, rsp_if.is_none);
            any_mismatch = 1'b1;
          end
        end
      end
      // advance the stall pattern; pick a new run pair when both are spent
      if (ready_run == 0 && stall_run == 0) begin
        ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
        stall_run = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
      end
      if (ready_run > 0) begin
        ready_run--;
        rsp_if.ready <= 1'b1;
      end else begin
        stall_run--;
        rsp_if.ready <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: load directed then random requests, release reset, drain.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;

    // absolute value, including the most negative value that stays unchanged
    push_req(MODE_ABS, S64_MIN, 0, 0);
    push_req(MODE_ABS, -5, 0, 0);
    push_req(MODE_ABS, S64_MAX, 0, 0);
    // min and max at the range ends
    push_req(MODE_MIN, S64_MIN, S64_MAX, 0);
    push_req(MODE_MAX, S64_MIN, S64_MAX, 0);
    push_req(MODE_MIN, -1, 1, 0);
    // clamp below, inside, above, and with crossed bounds (lo wins)
    push_req(MODE_CLAMP, -100, -10, 10);
    push_req(MODE_CLAMP, 3, -10, 10);
    push_req(MODE_CLAMP, S64_MAX, -10, 10);
    push_req(MODE_CLAMP, 0, 10, -10);
    // sign of negative, zero and positive
    push_req(MODE_SIGN, S64_MIN, 0, 0);
    push_req(MODE_SIGN, 0, 0, 0);
    push_req(MODE_SIGN, S64_MAX, 0, 0);
    // divide: by zero, wrap of most negative by minus one, sign mixes
    push_req(MODE_DIVMOD, 42, 0, 0);
    push_req(MODE_DIVMOD, S64_MIN, -1, 0);
    push_req(MODE_DIVMOD, -7, 2, 0);
    push_req(MODE_DIVMOD, 7, -2, 0);
    push_req(MODE_DIVMOD, S64_MAX, S64_MIN, 0);
    push_req(MODE_DIVMOD, S64_MIN, S64_MAX, 0);
    // gcd: both zero, 2^63 results, a minus-one operand, mixed signs
    push_req(MODE_GCD, 0, 0, 0);
    push_req(MODE_GCD, S64_MIN, 0, 0);
    push_req(MODE_GCD, S64_MIN, S64_MIN, 0);
    push_req(MODE_GCD, S64_MAX, -1, 0);
    push_req(MODE_GCD, -12, 18, 0);
    // unused mode code returns all zero
    push_req(MODE_UNUSED, S64_MIN, -1, S64_MAX);

    repeat (RANDOM_REQS) push_random_req();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything sent, everything answered, then let the unit settle
    while (pending_reqs.size() > 0 || req_if.valid) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!any_mismatch && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
